// ===== src/uar_pkg.sv =====
// ----------------------------------------------------------------------------
// uar_pkg: shared types and constants for the radix-to-ASCII converter
// Holds the request and response beat layouts, the controller-to-datapath
// command and status groups and the digit-to-character mapping.
// ----------------------------------------------------------------------------
package uar_pkg;

   localparam int unsigned NumberWidth = 16;
   localparam int unsigned RadixWidth  = 6;
   localparam int unsigned CharWidth   = 8;
   localparam int unsigned DigitWidth  = 6;

   localparam logic [RadixWidth-1:0] RadixMin = 6'd2;
   localparam logic [RadixWidth-1:0] RadixMax = 6'd36;

   localparam logic [CharWidth-1:0] CharZero   = 8'h30;
   localparam logic [CharWidth-1:0] CharNine   = 8'h39;
   localparam logic [CharWidth-1:0] LetterGap  = 8'd7;
   localparam logic [CharWidth-1:0] CharError  = 8'h00;

   typedef struct packed {
      logic [NumberWidth-1:0] number;
      logic [RadixWidth-1:0]  radix;
   } req_type;

   typedef struct packed {
      logic [CharWidth-1:0] character;
      logic                 last;
      logic                 bad_radix;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic div_step;
      logic store;
      logic rd_issue;
      logic emit;
      logic emit_error;
   } cmd_type;

   typedef struct packed {
      logic radix_ok;
      logic step_last;
      logic more_digits;
      logic index_zero;
   } status_type;

   function automatic logic [CharWidth-1:0] digit_char(input logic [DigitWidth-1:0] d);
      logic [CharWidth-1:0] c;
      c = CharZero + {2'b00, d};
      if (c > CharNine) begin
         c = c + LetterGap;
      end
      return c;
   endfunction

endpackage

// ===== src/unsigned_to_ascii_radix_core.sv =====
// ----------------------------------------------------------------------------
// unsigned_to_ascii_radix_core: unsigned number to ASCII digits in radix 2-36
// Top level joining the sequencing controller and the conversion datapath.
// ----------------------------------------------------------------------------
// Usage:
// A request beat (number, radix) is taken on a clock edge where start is
// high and busy is low. Digits are produced as upper-case ASCII characters,
// most significant first, one response beat per character on rsp_data,
// each marked by rsp_valid for exactly one cycle; the final beat has last
// set. A radix outside 2 to 36 yields a single beat with character zero,
// last and bad_radix set, in the cycle after the request, and busy stays low.
// While busy, each digit is computed by the one-bit-per-cycle restoring
// divider and then stored, and readout passes each character through the
// registered digit store read. Response beats cannot be held off by the
// receiver. Synchronous reset returns the controller to idle and drops
// rsp_valid; a conversion in progress is abandoned.
// ----------------------------------------------------------------------------
module unsigned_to_ascii_radix_core #(
   parameter int unsigned NUMBER_BITS = 16,
   parameter int unsigned MAX_DIGITS  = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  uar_pkg::req_type req_data,
   output logic             rsp_valid,
   output uar_pkg::rsp_type rsp_data
);

   uar_pkg::cmd_type    cmd;
   uar_pkg::status_type status;

   uar_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   uar_datapath #(
      .NUMBER_BITS (NUMBER_BITS),
      .MAX_DIGITS  (MAX_DIGITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== src/uar_ctrl.sv =====
// ----------------------------------------------------------------------------
// uar_ctrl: sequencing state machine
// Steps the datapath through loading, bit-serial division, digit storing
// and reversed readout, and reports when it is busy.
// ----------------------------------------------------------------------------
module uar_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  uar_pkg::status_type status,
   output uar_pkg::cmd_type    cmd
);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_DIVIDE = 5'b00010,
      ST_STORE  = 5'b00100,
      ST_READ   = 5'b01000,
      ST_EMIT   = 5'b10000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (status.radix_ok) begin
                  cmd.load = 1'b1;
                  state_in = ST_DIVIDE;
               end else begin
                  cmd.emit_error = 1'b1;
               end
            end
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (status.step_last) begin
               state_in = ST_STORE;
            end
         end
         ST_STORE: begin
            cmd.store = 1'b1;
            state_in  = status.more_digits ? ST_DIVIDE : ST_READ;
         end
         ST_READ: begin
            cmd.rd_issue = 1'b1;
            state_in     = ST_EMIT;
         end
         ST_EMIT: begin
            cmd.emit = 1'b1;
            state_in = status.index_zero ? ST_IDLE : ST_READ;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

   // An error beat never occupies the converter.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && !status.radix_ok) |=> !busy)
      else $error("busy raised for a bad radix");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && status.index_zero) |=> (state_ff == ST_IDLE))
      else $error("readout did not finish on the last digit");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_STORE && !status.more_digits) |=> (state_ff == ST_READ))
      else $error("readout not started after the final digit");

endmodule

// ===== src/uar_datapath.sv =====
// ----------------------------------------------------------------------------
// uar_datapath: divider, digit store and response register
// Restoring division by the radix one quotient bit per cycle, a digit store
// holding the remainders, and the registered response beat.
// ----------------------------------------------------------------------------
module uar_datapath #(
   parameter int unsigned NUMBER_BITS = 16,
   parameter int unsigned MAX_DIGITS  = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  uar_pkg::req_type    req_data,
   input  uar_pkg::cmd_type    cmd,
   output uar_pkg::status_type status,
   output logic                rsp_valid,
   output uar_pkg::rsp_type    rsp_data
);

   localparam int unsigned QW = NUMBER_BITS;
   localparam int unsigned SW = $clog2(NUMBER_BITS);
   localparam int unsigned CW = $clog2(MAX_DIGITS + 1);
   localparam int unsigned AW = $clog2(MAX_DIGITS);
   localparam int unsigned DW = uar_pkg::DigitWidth;

   logic [QW-1:0]                     quotient_ff, quotient_in;
   logic [DW-1:0]                     remainder_ff, remainder_in;
   logic [uar_pkg::RadixWidth-1:0]    radix_ff, radix_in;
   logic [SW-1:0]                     step_ff, step_in;
   logic [CW-1:0]                     count_ff, count_in;
   logic [AW-1:0]                     index_ff, index_in;
   logic [DW-1:0]                     rd_data_ff;
   logic                              rsp_valid_ff, rsp_valid_in;
   uar_pkg::rsp_type                  rsp_data_ff, rsp_data_in;

   logic [DW-1:0] digit_mem [MAX_DIGITS];

   logic [DW:0] partial;
   logic [DW:0] diff;
   logic        ge;

   assign partial = {remainder_ff, quotient_ff[QW-1]};
   assign diff    = partial - {1'b0, radix_ff};
   assign ge      = (partial >= {1'b0, radix_ff});

   assign status.radix_ok    = (req_data.radix >= uar_pkg::RadixMin) &&
                               (req_data.radix <= uar_pkg::RadixMax);
   assign status.step_last   = (step_ff == SW'(QW - 1));
   assign status.more_digits = (quotient_ff != '0) && (count_ff != CW'(MAX_DIGITS - 1));
   assign status.index_zero  = (index_ff == '0);

   always_comb begin
      quotient_in  = quotient_ff;
      remainder_in = remainder_ff;
      radix_in     = radix_ff;
      step_in      = step_ff;
      count_in     = count_ff;
      index_in     = index_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = rsp_data_ff;
      if (cmd.load) begin
         quotient_in  = QW'(req_data.number);
         remainder_in = '0;
         radix_in     = req_data.radix;
         step_in      = '0;
         count_in     = '0;
      end
      if (cmd.div_step) begin
         quotient_in  = {quotient_ff[QW-2:0], ge};
         remainder_in = ge ? diff[DW-1:0] : partial[DW-1:0];
         step_in      = step_ff + SW'(1);
      end
      if (cmd.store) begin
         remainder_in = '0;
         step_in      = '0;
         count_in     = count_ff + CW'(1);
         index_in     = count_ff[AW-1:0];
      end
      if (cmd.emit) begin
         rsp_valid_in          = 1'b1;
         rsp_data_in.character = uar_pkg::digit_char(rd_data_ff);
         rsp_data_in.last      = (index_ff == '0);
         rsp_data_in.bad_radix = 1'b0;
         index_in              = index_ff - AW'(1);
      end
      if (cmd.emit_error) begin
         rsp_valid_in          = 1'b1;
         rsp_data_in.character = uar_pkg::CharError;
         rsp_data_in.last      = 1'b1;
         rsp_data_in.bad_radix = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.store) begin
         digit_mem[count_ff[AW-1:0]] <= remainder_ff;
      end
      if (cmd.rd_issue) begin
         rd_data_ff <= digit_mem[index_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         quotient_ff  <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         quotient_ff  <= quotient_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      remainder_ff <= remainder_in;
      radix_ff     <= radix_in;
      step_ff      <= step_in;
      index_ff     <= index_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> (rsp_valid_ff && !rsp_data_ff.bad_radix))
      else $error("digit beat missing or flagged as an error");

   assert property (@(posedge clock) disable iff (reset)
      cmd.emit_error |=> (rsp_valid_ff && rsp_data_ff.last && rsp_data_ff.bad_radix))
      else $error("error beat malformed");

   assert property (@(posedge clock) disable iff (reset)
      cmd.store |-> (count_ff < CW'(MAX_DIGITS)))
      else $error("digit store overflow");

endmodule
